[design/tig_pkg.sv]
// shared types, constants and helpers for the tiger hash engine
`timescale 1ns / 1ps
package tig_pkg;

	localparam int SboxDepth = 1024;
	localparam int SboxAw = 10;

	localparam logic [63:0] IV0 = 64'h0123456789ABCDEF;
	localparam logic [63:0] IV1 = 64'hFEDCBA9876543210;
	localparam logic [63:0] IV2 = 64'hF096A5B4C3B2E187;
	localparam logic [63:0] KEY_A5 = 64'hA5A5A5A5A5A5A5A5;

	// register indexes on the configuration port
	localparam logic [1:0] REG_PASS_COUNT = 2'd0;
	localparam logic [1:0] REG_BYTE_ORDER = 2'd1;

	// 64-byte seed block used to generate the s-boxes, little-endian words
	localparam logic [63:0] SEED [8] = '{
		64'h202D207265676954, 64'h4E20747361462041,
		64'h2068736148207765, 64'h6E6F6974636E7546,
		64'h736F52207962202C, 64'h737265646E412073,
		64'h4520646E61206E6F, 64'h6D6168694220696C
	};

	// s-box memory request: one write port, two read ports
	typedef struct packed {
		logic              we;
		logic [SboxAw-1:0] waddr;
		logic [63:0]       wdata;
		logic [SboxAw-1:0] raddr0;
		logic [SboxAw-1:0] raddr1;
	} sram_req_t;

	function automatic logic [63:0] rev_bytes(input logic [63:0] v);
		logic [63:0] r;
		for (int k = 0; k < 8; k++) begin
			r[8*k +: 8] = v[8*(7-k) +: 8];
		end
		return r;
	endfunction

	function automatic logic [3:0] clamp_passes(input logic [3:0] p);
		logic [3:0] r;
		if (p < 4'd3) begin
			r = 4'd3;
		end else if (p > 4'd8) begin
			r = 4'd8;
		end else begin
			r = p;
		end
		return r;
	endfunction

endpackage

[design/tig_sbox_ram.sv]
// s-box storage: 1024 x 64 memory, one write port, two registered read ports
`timescale 1ns / 1ps
module tig_sbox_ram (
	input  logic                clk,
	input  tig_pkg::sram_req_t  req,
	output logic [63:0]         rdata0,
	output logic [63:0]         rdata1
);
	import tig_pkg::*;

	logic [63:0] mem [SboxDepth];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= mem[req.raddr0];
		rdata1 <= mem[req.raddr1];
	end

endmodule

[design/tiger_hash_engine_unit.sv]
// tiger hash engine top level: s-box generation, compression sequencer, padding
`timescale 1ns / 1ps
// Usage
// Input channel: in_valid / in_stall with message_word, valid_bytes, last.
// Words carry eight bytes, first byte in bits 7..0; the word marked last
// carries 0..8 bytes and closes the message.
// Output channel: out_valid / out_stall with digest_a, digest_b, digest_c,
// one transaction per message, held in an output register until taken.
// After reset the engine builds the four s-boxes in its own memory: a fill
// of all 1024 entries, then about 1707 three-pass compressions and 5120 byte
// swap rows; in_stall stays high until it is done.
// Configuration writes are taken at any time on cfg_wr_en.
// One compression runs P passes through one round unit that reads the
// s-box memory two entries per cycle.
// A word that fills no block leaves the engine idle and ready for the next
// word. A last word goes through a padding step, one or two compressions and
// an emit step that loads the result.
// When the receiver stalls with a digest waiting, the next message can still
// be absorbed; the engine waits only when a new digest is ready to load.
module tiger_hash_engine_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] message_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] digest_a,
	output logic [63:0] digest_b,
	output logic [63:0] digest_c,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	import tig_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT, ST_GSTEP, ST_SW_RD, ST_SW_WA, ST_SW_WB,
		ST_IDLE, ST_PAD, ST_CLRLEN, ST_EMIT,
		ST_CSTART, ST_RV, ST_RD, ST_F1, ST_F2, ST_SCHED, ST_FF
	} state_t;

	typedef enum logic [2:0] {
		RET_GEN, RET_ABSORB, RET_TOPAD, RET_PAD1, RET_FINAL
	} ret_t;

	state_t state_q;
	ret_t   ret_q;

	logic [SboxAw-1:0] init_cnt_q;
	logic [2:0]  gcnt_q;
	logic [7:0]  gidx_q;
	logic [1:0]  sb_q;
	logic [1:0]  abc_q;
	logic [2:0]  col_q;
	logic [63:0] new_b_q;

	logic [63:0] cv_q [3];
	logic [63:0] wa_q, wb_q, wc_q;
	logic [63:0] x_q [8];
	logic [63:0] acc_a_q, acc_b_q;
	logic [1:0]  rd_q;
	logic [2:0]  round_q;
	logic [2:0]  pass_q;
	logic [3:0]  passes_q;
	logic [3:0]  step_q;

	logic [2:0]  fill_q;
	logic [54:0] blk_q;
	logic [3:0]  pend_v_q;
	logic [63:0] pend_w_q;
	logic [63:0] len_q;

	logic [3:0]  pass_cfg_q;
	logic        order_cfg_q;

	logic        out_valid_q;
	logic [63:0] dig_a_q, dig_b_q, dig_c_q;

	sram_req_t   ram_req;
	logic [63:0] rdata0, rdata1;

	logic [63:0] cv_sel;
	logic [7:0]  swap_byte;
	logic [63:0] swap_mask;
	logic [63:0] sched_res;
	logic [63:0] sub_k;
	logic [63:0] mul_res;
	logic [63:0] pad_word;
	logic [63:0] pad_len;
	logic [3:0]  v_eff;
	logic        in_acc;

	tig_sbox_ram u_sbox (
		.clk    (clk),
		.req    (ram_req),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign digest_a = dig_a_q;
	assign digest_b = dig_b_q;
	assign digest_c = dig_c_q;

	assign cv_sel = cv_q[abc_q];
	assign swap_byte = cv_sel[{col_q, 3'b000} +: 8];
	assign swap_mask = 64'hFF << {col_q, 3'b000};
	assign v_eff = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
	assign pad_len = {blk_q, fill_q, pend_v_q[2:0], 3'b000};

	// s-box memory port selection
	always_comb begin
		ram_req.we = 1'b0;
		ram_req.waddr = {sb_q, gidx_q};
		ram_req.wdata = new_b_q;
		ram_req.raddr0 = {sb_q, gidx_q};
		ram_req.raddr1 = {sb_q, swap_byte};
		case (state_q)
			ST_INIT: begin
				ram_req.we = 1'b1;
				ram_req.waddr = init_cnt_q;
				ram_req.wdata = {8{init_cnt_q[7:0]}};
			end
			ST_SW_WA: begin
				ram_req.we = 1'b1;
				ram_req.wdata = (rdata0 & ~swap_mask) | (rdata1 & swap_mask);
			end
			ST_SW_WB: begin
				ram_req.we = 1'b1;
				ram_req.waddr = {sb_q, swap_byte};
			end
			ST_RD: begin
				// a-side table t reads even byte 2t, b-side table 3-t odd byte 2t+1
				ram_req.raddr0 = {rd_q, wc_q[{rd_q, 4'b0000} +: 8]};
				ram_req.raddr1 = {~rd_q, wc_q[{rd_q, 4'b1000} +: 8]};
			end
			default: begin
			end
		endcase
	end

	// key schedule step on the rotating word line
	always_comb begin
		case (step_q) inside
			4'd0:        sub_k = x_q[7] ^ KEY_A5;
			4'd15:       sub_k = x_q[7] ^ IV0;
			4'd3, 4'd9:  sub_k = x_q[7] ^ ((~x_q[6]) << 19);
			default:     sub_k = x_q[7] ^ ((~x_q[6]) >> 23);
		endcase
		case (step_q) inside
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13: sched_res = x_q[0] ^ x_q[7];
			4'd2, 4'd5, 4'd8, 4'd11, 4'd14: sched_res = x_q[0] + x_q[7];
			default:                        sched_res = x_q[0] - sub_k;
		endcase
	end

	always_comb begin
		case (pass_q)
			3'd0:    mul_res = wb_q + (wb_q << 2);
			3'd1:    mul_res = (wb_q << 3) - wb_q;
			default: mul_res = wb_q + (wb_q << 3);
		endcase
	end

	// final word: kept bytes, then the 0x01 marker, then zeros
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			if (4'(k) < pend_v_q) begin
				pad_word[8*k +: 8] = pend_w_q[8*k +: 8];
			end else if (4'(k) == pend_v_q) begin
				pad_word[8*k +: 8] = 8'h01;
			end else begin
				pad_word[8*k +: 8] = 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_cfg_q <= 4'd3;
			order_cfg_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PASS_COUNT: pass_cfg_q <= cfg_data;
				REG_BYTE_ORDER: order_cfg_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ret_q <= RET_GEN;
			init_cnt_q <= '0;
			gcnt_q <= '0;
			gidx_q <= '0;
			sb_q <= '0;
			abc_q <= 2'd2;
			col_q <= '0;
			rd_q <= '0;
			round_q <= '0;
			pass_q <= '0;
			passes_q <= 4'd3;
			step_q <= '0;
			fill_q <= '0;
			blk_q <= '0;
			out_valid_q <= 1'b0;
			cv_q[0] <= IV0;
			cv_q[1] <= IV1;
			cv_q[2] <= IV2;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == SboxAw'(SboxDepth - 1)) begin
						state_q <= ST_GSTEP;
					end
				end
				ST_GSTEP: begin
					col_q <= '0;
					if (abc_q == 2'd2) begin
						abc_q <= 2'd0;
						for (int k = 0; k < 8; k++) begin
							x_q[k] <= SEED[k];
						end
						ret_q <= RET_GEN;
						state_q <= ST_CSTART;
					end else begin
						abc_q <= abc_q + 1'b1;
						state_q <= ST_SW_RD;
					end
				end
				ST_SW_RD: state_q <= ST_SW_WA;
				ST_SW_WA: begin
					new_b_q <= (rdata1 & ~swap_mask) | (rdata0 & swap_mask);
					state_q <= ST_SW_WB;
				end
				ST_SW_WB: begin
					col_q <= col_q + 1'b1;
					if (col_q == 3'd7) begin
						sb_q <= sb_q + 1'b1;
						state_q <= ST_GSTEP;
						if (sb_q == 2'd3) begin
							gidx_q <= gidx_q + 1'b1;
							if (gidx_q == 8'd255) begin
								gcnt_q <= gcnt_q + 1'b1;
								if (gcnt_q == 3'd4) begin
									cv_q[0] <= IV0;
									cv_q[1] <= IV1;
									cv_q[2] <= IV2;
									state_q <= ST_IDLE;
								end
							end
						end
					end else begin
						state_q <= ST_SW_RD;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						pend_w_q <= message_word;
						if (!last || v_eff == 4'd8) begin
							x_q[fill_q] <= message_word;
							fill_q <= fill_q + 1'b1;
						end
						if (!last) begin
							if (fill_q == 3'd7) begin
								ret_q <= RET_ABSORB;
								state_q <= ST_CSTART;
							end
						end else if (v_eff == 4'd8) begin
							pend_v_q <= 4'd0;
							if (fill_q == 3'd7) begin
								ret_q <= RET_TOPAD;
								state_q <= ST_CSTART;
							end else begin
								state_q <= ST_PAD;
							end
						end else begin
							pend_v_q <= v_eff;
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					len_q <= pad_len;
					for (int k = 0; k < 8; k++) begin
						if (3'(k) == fill_q) begin
							x_q[k] <= pad_word;
						end else if (3'(k) > fill_q) begin
							x_q[k] <= (k == 7) ? pad_len : 64'd0;
						end
					end
					ret_q <= (fill_q == 3'd7) ? RET_PAD1 : RET_FINAL;
					state_q <= ST_CSTART;
				end
				ST_CLRLEN: begin
					for (int k = 0; k < 7; k++) begin
						x_q[k] <= 64'd0;
					end
					x_q[7] <= len_q;
					ret_q <= RET_FINAL;
					state_q <= ST_CSTART;
				end
				ST_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						dig_a_q <= order_cfg_q ? rev_bytes(cv_q[0]) : cv_q[0];
						dig_b_q <= order_cfg_q ? rev_bytes(cv_q[1]) : cv_q[1];
						dig_c_q <= order_cfg_q ? rev_bytes(cv_q[2]) : cv_q[2];
						out_valid_q <= 1'b1;
						cv_q[0] <= IV0;
						cv_q[1] <= IV1;
						cv_q[2] <= IV2;
						fill_q <= '0;
						blk_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_CSTART: begin
					wa_q <= cv_q[0];
					wb_q <= cv_q[1];
					wc_q <= cv_q[2];
					pass_q <= '0;
					round_q <= '0;
					passes_q <= (ret_q == RET_GEN) ? 4'd3 : clamp_passes(pass_cfg_q);
					state_q <= ST_RV;
				end
				ST_RV: begin
					wc_q <= wc_q ^ x_q[0];
					rd_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (rd_q == 2'd1) begin
						acc_a_q <= rdata0;
						acc_b_q <= rdata1;
					end else if (rd_q != 2'd0) begin
						acc_a_q <= acc_a_q ^ rdata0;
						acc_b_q <= acc_b_q ^ rdata1;
					end
					rd_q <= rd_q + 1'b1;
					if (rd_q == 2'd3) begin
						state_q <= ST_F1;
					end
				end
				ST_F1: begin
					wa_q <= wa_q - (acc_a_q ^ rdata0);
					wb_q <= wb_q + (acc_b_q ^ rdata1);
					state_q <= ST_F2;
				end
				ST_F2: begin
					// roles move on by one register; after a pass this matches the swap
					wa_q <= mul_res;
					wb_q <= wc_q;
					wc_q <= wa_q;
					for (int k = 0; k < 7; k++) begin
						x_q[k] <= x_q[k+1];
					end
					x_q[7] <= x_q[0];
					round_q <= round_q + 1'b1;
					if (round_q == 3'd7) begin
						if ({1'b0, pass_q} == passes_q - 4'd1) begin
							state_q <= ST_FF;
						end else begin
							pass_q <= pass_q + 1'b1;
							step_q <= '0;
							state_q <= ST_SCHED;
						end
					end else begin
						state_q <= ST_RV;
					end
				end
				ST_SCHED: begin
					for (int k = 0; k < 7; k++) begin
						x_q[k] <= x_q[k+1];
					end
					x_q[7] <= sched_res;
					step_q <= step_q + 1'b1;
					if (step_q == 4'd15) begin
						state_q <= ST_RV;
					end
				end
				ST_FF: begin
					cv_q[0] <= cv_q[0] ^ wa_q;
					cv_q[1] <= wb_q - cv_q[1];
					cv_q[2] <= cv_q[2] + wc_q;
					case (ret_q)
						RET_GEN: state_q <= ST_SW_RD;
						RET_ABSORB: begin
							blk_q <= blk_q + 1'b1;
							state_q <= ST_IDLE;
						end
						RET_TOPAD: begin
							blk_q <= blk_q + 1'b1;
							state_q <= ST_PAD;
						end
						RET_PAD1: state_q <= ST_CLRLEN;
						RET_FINAL: state_q <= ST_EMIT;
						default: state_q <= ST_IDLE;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last) |=> in_stall)
		else $error("engine took a word right after a final transaction");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_EMIT))
		else $error("digest raised outside the emit step");

	a_no_write_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RV || state_q == ST_RD || state_q == ST_F1 ||
		 state_q == ST_F2 || state_q == ST_SCHED) |-> !ram_req.we)
		else $error("s-box written during compression");
`endif

endmodule
